>>> rtl/core/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg
// Types and constants shared by the stereo stream mixer: item structs, the
// decoded command that travels from the front end to the mixing back end.
// ----------------------------------------------------------------------------
package smx_pkg;

   localparam int STREAMS     = 8;
   localparam int IDX_W       = (STREAMS > 1) ? $clog2(STREAMS) : 1;
   localparam int MASK_W      = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [16:0] GAIN_UNITY = 17'h10000;

   localparam logic signed [18:0] PCM_MAX = 19'sd32767;
   localparam logic signed [18:0] PCM_MIN = -19'sd32768;

   typedef enum logic [1:0] {
      FUNC_SAMPLE = 2'd0,
      FUNC_START  = 2'd1,
      FUNC_STOP   = 2'd2,
      FUNC_GAIN   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_SAMPLE,
      OP_END,
      OP_START,
      OP_STOP,
      OP_GAIN
   } op_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [2:0]         stream;
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic               src_ended;
      logic               frame_end;
      logic [16:0]        gain;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] mix_left;
      logic signed [15:0] mix_right;
      logic [7:0]         finished_mask;
      logic [7:0]         active_mask;
   } rsp_item_type;

   typedef struct packed {
      op_type             op;
      logic [IDX_W-1:0]   idx;
      logic               frame_end;
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic [16:0]        gain;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

   typedef struct packed {
      logic valid;
      logic frame_end;
   } back_stat_type;

endpackage

>>> rtl/core/smx_front.sv
// ----------------------------------------------------------------------------
// smx_front
// Accepts request items and decodes them into mixer commands for the queue.
// ----------------------------------------------------------------------------
module smx_front (
   input  logic                  req_valid,
   input  smx_pkg::req_item_type req_item,
   input  logic                  q_full,
   output logic                  req_stall,
   output logic                  q_push,
   output smx_pkg::cmd_type      q_cmd
);

   logic in_range;

   assign in_range  = (32'(req_item.stream) < 32'(smx_pkg::STREAMS));
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_cmd.idx       = smx_pkg::IDX_W'(req_item.stream);
      q_cmd.frame_end = req_item.frame_end;
      q_cmd.left      = req_item.left;
      q_cmd.right     = req_item.right;
      q_cmd.gain      = req_item.gain;
      q_cmd.op        = smx_pkg::OP_NOP;
      if (in_range) begin
         unique case (smx_pkg::func_type'(req_item.func))
            smx_pkg::FUNC_SAMPLE: begin
               q_cmd.op = req_item.src_ended ? smx_pkg::OP_END : smx_pkg::OP_SAMPLE;
            end
            smx_pkg::FUNC_START: q_cmd.op = smx_pkg::OP_START;
            smx_pkg::FUNC_STOP:  q_cmd.op = smx_pkg::OP_STOP;
            smx_pkg::FUNC_GAIN:  q_cmd.op = smx_pkg::OP_GAIN;
            default:             q_cmd.op = smx_pkg::OP_NOP;
         endcase
      end
   end

endmodule

>>> rtl/core/smx_queue.sv
// ----------------------------------------------------------------------------
// smx_queue
// Short command queue between the front end and the mixing back end.
// ----------------------------------------------------------------------------
module smx_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  smx_pkg::cmd_type     push_cmd,
   input  logic                 pop,
   output logic                 full,
   output smx_pkg::q_head_type  head
);

   smx_pkg::cmd_type            slot_ff [smx_pkg::QUEUE_DEPTH];
   logic [smx_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [smx_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [smx_pkg::QCNT_W-1:0]  count_ff, count_in;
   logic                        do_pop;

   assign full   = (count_ff == smx_pkg::QCNT_W'(smx_pkg::QUEUE_DEPTH));
   assign head   = '{valid: (count_ff != '0), cmd: slot_ff[rd_ptr_ff]};
   assign do_pop = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == smx_pkg::QPTR_W'(smx_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == smx_pkg::QPTR_W'(smx_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/core/smx_back.sv
// ----------------------------------------------------------------------------
// smx_back
// Mixing back end: updates per-stream state and scales the sample, then
// accumulates with saturation and registers the frame result.
// ----------------------------------------------------------------------------
module smx_back (
   input  logic                    clock,
   input  logic                    reset,
   input  smx_pkg::q_head_type     head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output smx_pkg::rsp_item_type   rsp_item,
   output smx_pkg::back_stat_type  stat
);

   logic [smx_pkg::STREAMS-1:0] active_ff, active_in;
   logic [smx_pkg::STREAMS-1:0] finished_ff, finished_in;
   logic [16:0]                 gain_ff [smx_pkg::STREAMS];
   logic [16:0]                 gain_in [smx_pkg::STREAMS];

   logic                        adv;
   logic                        add_en;
   logic [16:0]                 cur_gain;
   logic signed [33:0]          prod_l, prod_r;
   logic signed [33:0]          rnd_l, rnd_r;
   logic signed [17:0]          scaled_l, scaled_r;
   logic [smx_pkg::MASK_W-1:0]  amask, fmask;

   logic                        b_valid_ff;
   logic                        b_fend_ff;
   logic signed [17:0]          b_left_ff, b_right_ff;
   logic [smx_pkg::MASK_W-1:0]  b_amask_ff, b_fmask_ff;

   logic signed [15:0]          acc_left_ff, acc_right_ff;
   logic signed [18:0]          sum_l, sum_r;
   logic signed [15:0]          sat_l, sat_r;

   logic                        rsp_valid_ff;
   smx_pkg::rsp_item_type       rsp_item_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign pop       = adv && head.valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign stat      = '{valid: b_valid_ff, frame_end: b_fend_ff};

   assign cur_gain = gain_ff[head.cmd.idx];
   assign add_en   = (head.cmd.op == smx_pkg::OP_SAMPLE) && active_ff[head.cmd.idx];

   always_comb begin
      prod_l   = head.cmd.left  * $signed({1'b0, cur_gain});
      prod_r   = head.cmd.right * $signed({1'b0, cur_gain});
      rnd_l    = prod_l + (prod_l[33] ? 34'sd65535 : 34'sd0);
      rnd_r    = prod_r + (prod_r[33] ? 34'sd65535 : 34'sd0);
      scaled_l = add_en ? rnd_l[33:16] : '0;
      scaled_r = add_en ? rnd_r[33:16] : '0;
   end

   always_comb begin
      active_in   = active_ff;
      finished_in = finished_ff;
      gain_in     = gain_ff;
      if (pop) begin
         unique case (head.cmd.op)
            smx_pkg::OP_END: begin
               if (active_ff[head.cmd.idx]) begin
                  active_in[head.cmd.idx]   = 1'b0;
                  finished_in[head.cmd.idx] = 1'b1;
               end
            end
            smx_pkg::OP_START: begin
               active_in[head.cmd.idx]   = 1'b1;
               finished_in[head.cmd.idx] = 1'b0;
            end
            smx_pkg::OP_STOP: begin
               active_in[head.cmd.idx]   = 1'b0;
               finished_in[head.cmd.idx] = 1'b1;
            end
            smx_pkg::OP_GAIN: gain_in[head.cmd.idx] = head.cmd.gain;
            default: ;
         endcase
      end
   end

   always_comb begin
      amask = '0;
      fmask = '0;
      for (int i = 0; i < smx_pkg::MASK_W; i++) begin
         if (i < smx_pkg::STREAMS) begin
            amask[i] = active_in[i];
            fmask[i] = finished_in[i];
         end
      end
   end

   always_comb begin
      sum_l = 19'(acc_left_ff)  + 19'(b_left_ff);
      sum_r = 19'(acc_right_ff) + 19'(b_right_ff);
      if (sum_l > smx_pkg::PCM_MAX) begin
         sat_l = 16'(smx_pkg::PCM_MAX);
      end else if (sum_l < smx_pkg::PCM_MIN) begin
         sat_l = 16'(smx_pkg::PCM_MIN);
      end else begin
         sat_l = sum_l[15:0];
      end
      if (sum_r > smx_pkg::PCM_MAX) begin
         sat_r = 16'(smx_pkg::PCM_MAX);
      end else if (sum_r < smx_pkg::PCM_MIN) begin
         sat_r = 16'(smx_pkg::PCM_MIN);
      end else begin
         sat_r = sum_r[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         finished_ff  <= '0;
         for (int i = 0; i < smx_pkg::STREAMS; i++) begin
            gain_ff[i] <= smx_pkg::GAIN_UNITY;
         end
         b_valid_ff   <= 1'b0;
         b_fend_ff    <= 1'b0;
         acc_left_ff  <= '0;
         acc_right_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff   <= active_in;
         finished_ff <= finished_in;
         gain_ff     <= gain_in;
         if (adv) begin
            b_valid_ff <= head.valid;
            b_fend_ff  <= head.valid && head.cmd.frame_end;
            if (b_valid_ff) begin
               acc_left_ff  <= b_fend_ff ? '0 : sat_l;
               acc_right_ff <= b_fend_ff ? '0 : sat_r;
            end
            rsp_valid_ff <= b_valid_ff && b_fend_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b_left_ff  <= scaled_l;
         b_right_ff <= scaled_r;
         b_amask_ff <= amask;
         b_fmask_ff <= fmask;
      end
      if (adv && b_valid_ff && b_fend_ff) begin
         rsp_item_ff.mix_left      <= sat_l;
         rsp_item_ff.mix_right     <= sat_r;
         rsp_item_ff.finished_mask <= b_fmask_ff;
         rsp_item_ff.active_mask   <= b_amask_ff;
      end
   end

endmodule

>>> rtl/core/stereo_stream_mixer_saturating_unit.sv
// ----------------------------------------------------------------------------
// stereo_stream_mixer_saturating_unit
// Saturating stereo PCM mixer over up to eight source streams.
// ----------------------------------------------------------------------------
// Request items (req_) carry one command each: a sample for a stream, start,
// stop or set-gain. Samples of active streams are scaled by the stream's Q16
// gain, truncated toward zero and added to the left and right mix with
// 16-bit saturation after each add. An item with frame_end set produces one
// response item (rsp_) holding the mix and the finished and active stream
// masks as they stand after that item; the mix then restarts from zero.
// Items without frame_end produce no response.
// One item is taken per cycle while req_stall is low. After its closing item
// is accepted, a response passes through the command queue, then the state
// update with the gain multiply into the back-end stage register, then the
// saturating accumulator into the output register.
// When rsp_stall holds the output register, the back end halts and the
// two-entry command queue fills; req_stall rises once it is full.
// Reset clears the queue and the mix, marks every stream inactive and not
// finished, and sets every gain to unity.
// ----------------------------------------------------------------------------
module stereo_stream_mixer_saturating_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  smx_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output smx_pkg::rsp_item_type rsp_item
);

   logic                   q_push;
   logic                   q_full;
   smx_pkg::cmd_type       q_cmd;
   smx_pkg::q_head_type    q_head;
   smx_pkg::back_stat_type b_stat;
   logic                   q_pop;

   smx_front u_front (
      .req_valid (req_valid),
      .req_item  (req_item),
      .q_full    (q_full),
      .req_stall (req_stall),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   smx_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .head     (q_head)
   );

   smx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .stat      (b_stat)
   );

   a_accept_queued: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> q_head.valid)
      else $error("accepted item missing from command queue");

   a_rsp_from_frame_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(b_stat.valid && b_stat.frame_end))
      else $error("response without a closing item");

   a_masks_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_item.active_mask & rsp_item.finished_mask) == 8'd0))
      else $error("stream both active and finished");

endmodule
